[rtl/b64d_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and character helpers for the base64 decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

    localparam int COUNT_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [5:0] SX_PLUS    = 6'd62;
    localparam logic [5:0] SX_SLASH   = 6'd63;
    localparam logic [31:0] COUNT_CLAMP = 32'hFFFF_FFFF;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_LEFTOVER = 2'd2
    } t_status;

    // decoded character: six-bit value, flag for a non-alphabet code
    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } t_sextet;

    // one queued job: a decoded group or an end-of-string report
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  nres;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        t_status     status;
        logic [31:0] count;
    } t_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet    r;
        logic [7:0] d;
        r.bad = 1'b0;
        r.val = 6'd0;
        d     = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d     = ch - 8'h41;
            r.val = d[5:0];
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d     = ch - 8'h47;
            r.val = d[5:0];
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            d     = ch + 8'h04;
            r.val = d[5:0];
        end else if (ch == CH_PLUS) begin
            r.val = SX_PLUS;
        end else if (ch == CH_SLASH) begin
            r.val = SX_SLASH;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch >= 8'h09 && ch <= 8'h0D) || ch == CH_SPACE;
    endfunction

endpackage
`default_nettype wire

[rtl/b64d_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_front
// Classifies characters, assembles groups of four and queues decode jobs.
// ---------------------------------------------------------------------------
module b64d_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic           i_req_type,
    input  wire logic [7:0]     i_char_byte,
    output logic                o_push,
    output b64d_pkg::t_tok      o_tok
);

    localparam int CW = b64d_pkg::COUNT_W;

    logic [1:0]          r_fill, n_fill;
    logic                r_pad, n_pad;
    logic                r_err, n_err;
    logic [CW-1:0]       r_total, n_total;

    b64d_pkg::t_sextet   r_sx    [3];
    logic                r_ispad [3];
    logic                wr_en;

    b64d_pkg::t_sextet   sx;
    logic                ch_pad;
    logic                p2;
    logic                grp_bad;
    logic [1:0]          nb;
    logic [CW:0]         sum;
    logic [63:0]         total_ext;
    logic [31:0]         count_rep;

    always_comb begin
        sx        = b64d_pkg::sextet_of(i_char_byte);
        ch_pad    = (i_char_byte == b64d_pkg::PAD_CHAR);
        p2        = r_ispad[2];
        nb        = 2'd3 - {1'b0, ch_pad} - {1'b0, p2};
        grp_bad   = r_sx[0].bad || r_sx[1].bad
                  || (!(ch_pad && p2) && r_sx[2].bad)
                  || (!ch_pad && !p2 && sx.bad);
        sum       = {1'b0, r_total} + (CW+1)'(nb);
        total_ext = 64'(r_total);
        count_rep = (total_ext > 64'(b64d_pkg::COUNT_CLAMP)) ? b64d_pkg::COUNT_CLAMP
                                                             : total_ext[31:0];

        n_fill  = r_fill;
        n_pad   = r_pad;
        n_err   = r_err;
        n_total = r_total;
        wr_en   = 1'b0;
        o_push  = 1'b0;

        o_tok.kind   = b64d_pkg::KIND_DATA;
        o_tok.nres   = nb;
        o_tok.b0     = {r_sx[0].val, r_sx[1].val[5:4]};
        o_tok.b1     = {r_sx[1].val[3:0], r_sx[2].val[5:2]};
        o_tok.b2     = {r_sx[2].val[1:0], sx.val};
        o_tok.status = b64d_pkg::ST_OK;
        o_tok.count  = 32'd0;

        if (i_accept) begin
            if (i_req_type) begin
                // end of string: report and clear
                o_push      = 1'b1;
                o_tok.kind  = b64d_pkg::KIND_END;
                o_tok.nres  = 2'd1;
                o_tok.count = count_rep;
                if (r_err) begin
                    o_tok.status = b64d_pkg::ST_INVALID;
                end else if (r_fill != 2'd0) begin
                    o_tok.status = b64d_pkg::ST_LEFTOVER;
                    o_tok.count  = 32'd0;
                end
                n_fill  = 2'd0;
                n_pad   = 1'b0;
                n_err   = 1'b0;
                n_total = '0;
            end else if (!r_err && !b64d_pkg::is_blank(i_char_byte)) begin
                if (r_pad) begin
                    n_err = 1'b1;
                end else if (r_fill != 2'd3) begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + 2'd1;
                end else begin
                    n_fill = 2'd0;
                    if (grp_bad) begin
                        n_err = 1'b1;
                    end else begin
                        o_push  = 1'b1;
                        n_pad   = ch_pad || p2;
                        n_total = sum[CW] ? '1 : sum[CW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= 2'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
            r_total <= '0;
        end else begin
            r_fill  <= n_fill;
            r_pad   <= n_pad;
            r_err   <= n_err;
            r_total <= n_total;
        end
    end

    // group characters carry no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_sx[r_fill]    <= sx;
            r_ispad[r_fill] <= ch_pad;
        end
    end

endmodule
`default_nettype wire

[rtl/b64d_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_fifo
// Short job queue between the group assembler and the result serialiser.
// ---------------------------------------------------------------------------
module b64d_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire b64d_pkg::t_tok     i_tok,
    input  wire logic               i_pop,
    output b64d_pkg::t_tok          o_head,
    output b64d_pkg::t_fifo_stat    o_stat
);

    localparam int AW = b64d_pkg::FIFO_AW;
    localparam int CW = b64d_pkg::FIFO_CW;

    b64d_pkg::t_tok     r_mem [b64d_pkg::FIFO_DEPTH];
    logic [AW-1:0]      r_wr, n_wr;
    logic [AW-1:0]      r_rd, n_rd;
    logic [CW-1:0]      r_cnt, n_cnt;

    always_comb begin
        o_stat.full  = (r_cnt == CW'(b64d_pkg::FIFO_DEPTH));
        o_stat.empty = (r_cnt == '0);
        o_head       = r_mem[r_rd];
        n_wr  = i_push ? r_wr + AW'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + AW'(1) : r_rd;
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

endmodule
`default_nettype wire

[rtl/b64d_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_back
// Unrolls each queued job into result words through the output register.
// ---------------------------------------------------------------------------
module b64d_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire b64d_pkg::t_tok     i_head,
    input  wire logic               i_empty,
    output logic                    o_pop,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic                    o_out_kind,
    output logic [7:0]              o_data_byte,
    output logic [1:0]              o_status,
    output logic [31:0]             o_byte_count,
    output logic                    o_last
);

    logic [1:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic        load;
    logic        idx_last;
    logic [7:0]  sel_byte;

    always_comb begin
        load     = !i_empty && (!r_valid || !i_stall);
        idx_last = (r_idx == i_head.nres - 2'd1);
        o_pop    = load && idx_last;
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = idx_last ? 2'd0 : r_idx + 2'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_out_kind <= i_head.kind;
            o_last     <= idx_last;
            if (i_head.kind == b64d_pkg::KIND_END) begin
                o_data_byte  <= 8'd0;
                o_status     <= i_head.status;
                o_byte_count <= i_head.count;
            end else begin
                o_data_byte  <= sel_byte;
                o_status     <= b64d_pkg::ST_OK;
                o_byte_count <= 32'd0;
            end
        end
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

[rtl/base64_stream_decoder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, standard alphabet, with end-of-string status.
// ---------------------------------------------------------------------------
// One character word is taken every clock cycle while o_stall is low. The
// front end drops whitespace, gathers four characters and decodes the group
// in the cycle its fourth character arrives; it queues either a group of one
// to three bytes or, on an end-of-string word, a status report. The back end
// drains the four-entry queue one result word per cycle while i_stall is low,
// through a registered output, so a three-byte group gives three words. Input
// stalls only when that queue is full, so with i_stall low the sustained
// throughput is one character per cycle. The completing character's first byte
// passes through the queue and the output register. Results: data words
// (out_kind 0), one end status (out_kind 1, status, saturated byte_count); last
// marks each word's final result; later characters after an error are ignored.
// ---------------------------------------------------------------------------
module base64_stream_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic           i_req_type,
    input  wire logic [7:0]     i_char_byte,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic                o_out_kind,
    output logic [7:0]          o_data_byte,
    output logic [1:0]          o_status,
    output logic [31:0]         o_byte_count,
    output logic                o_last
);

    logic                   accept;
    logic                   push;
    logic                   pop;
    b64d_pkg::t_tok         tok;
    b64d_pkg::t_tok         head;
    b64d_pkg::t_fifo_stat   fstat;

    // hold the input while the job queue is full
    assign o_stall = fstat.full;
    assign accept  = i_valid && !o_stall;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_char_byte (i_char_byte),
        .o_push      (push),
        .o_tok       (tok)
    );

    b64d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (tok),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fstat)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (fstat.empty),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_kind   (o_out_kind),
        .o_data_byte  (o_data_byte),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fstat.full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fstat.empty)
        else $error("job popped from empty queue");

    // an end-of-string word reaches the queue in the cycle it is taken
    a_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type) |-> push)
        else $error("end-of-string word not queued");

    // an end status is always the sole, final result of its word
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind) |-> (o_last && o_data_byte == 8'd0))
        else $error("end status not marked last");

endmodule
`default_nettype wire
